// ===== rtl/core/sqo_pkg.sv =====
// Package: widths, stage types and helpers for the segment/square overlap test.
`default_nettype none
package sqo_pkg;

  localparam int COORD_W = 16;               // coordinate width
  localparam int SIDE_W  = 15;               // square side width
  localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
  localparam int X1_W    = COORD_W + 2;      // far corner, corner + side
  localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
  localparam int K_W     = PROD_W + 3;       // sum of up to four products
  localparam int IN_W    = 6 * COORD_W;      // packed request width
  localparam int OUT_W   = 8;                // result padded to a byte

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(100);

  typedef struct packed {
    logic signed [COORD_W-1:0] sq_x;
    logic signed [COORD_W-1:0] sq_y;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
  } req_t;

  // products and early flags handed from the prep stage to the eval stage
  typedef struct packed {
    logic signed [PROD_W-1:0] dx_dy0;   // cdx * (y0 - py)
    logic signed [PROD_W-1:0] dy_dx0;   // cdy * (x0 - px)
    logic signed [PROD_W-1:0] dx_s;     // cdx * side
    logic signed [PROD_W-1:0] dy_s;     // cdy * side
    logic                     pt_in;    // an endpoint lies in the closed square
    logic [3:0]               edge_opp; // endpoints straddle edge line: b, r, t, l
  } stg_t;

  // true when a and b lie strictly on opposite sides of ref
  function automatic logic straddle(input logic signed [X1_W-1:0] a,
                                    input logic signed [X1_W-1:0] b,
                                    input logic signed [X1_W-1:0] ref_v);
    return ((a > ref_v) && (b < ref_v)) || ((a < ref_v) && (b > ref_v));
  endfunction

  function automatic logic opp_sign(input logic signed [K_W-1:0] a,
                                    input logic signed [K_W-1:0] b);
    return ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sqo_prep.sv =====
// Prep stage: differences, the four cross-product terms, the endpoint test and the edge straddle flags.
`default_nettype none
module sqo_prep
  import sqo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              a_vld,
  output logic                   a_rdy,
  input  wire req_t              a_req,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   b_vld,
  input  wire logic              b_rdy,
  output stg_t                   b_stg
);

  logic              vld_r;
  stg_t              stg_r;
  stg_t              stg_nxt;
  logic              adv;

  logic signed [X1_W-1:0]   x0, y0, x1, y1, px, py, qx, qy, sd;
  logic signed [DIFF_W-1:0] cdx, cdy, dx0, dy0, sd17;

  always_comb begin
    sd   = $signed({{(X1_W-SIDE_W){1'b0}}, side});
    sd17 = $signed({{(DIFF_W-SIDE_W){1'b0}}, side});
    x0 = X1_W'(a_req.sq_x);
    y0 = X1_W'(a_req.sq_y);
    px = X1_W'(a_req.px);
    py = X1_W'(a_req.py);
    qx = X1_W'(a_req.qx);
    qy = X1_W'(a_req.qy);
    x1 = x0 + sd;
    y1 = y0 + sd;
    cdx = DIFF_W'(a_req.qx) - DIFF_W'(a_req.px);
    cdy = DIFF_W'(a_req.qy) - DIFF_W'(a_req.py);
    dx0 = DIFF_W'(a_req.sq_x) - DIFF_W'(a_req.px);
    dy0 = DIFF_W'(a_req.sq_y) - DIFF_W'(a_req.py);

    stg_nxt.dx_dy0 = PROD_W'(cdx * dy0);
    stg_nxt.dy_dx0 = PROD_W'(cdy * dx0);
    stg_nxt.dx_s   = PROD_W'(cdx * sd17);
    stg_nxt.dy_s   = PROD_W'(cdy * sd17);
    stg_nxt.pt_in  = (px >= x0 && px <= x1 && py >= y0 && py <= y1) ||
                     (qx >= x0 && qx <= x1 && qy >= y0 && qy <= y1);
    // zero side makes all corner terms equal, so no edge counts as crossed
    stg_nxt.edge_opp[0] = straddle(py, qy, y0);
    stg_nxt.edge_opp[1] = straddle(px, qx, x1);
    stg_nxt.edge_opp[2] = straddle(py, qy, y1);
    stg_nxt.edge_opp[3] = straddle(px, qx, x0);
  end

  assign a_rdy = !vld_r || b_rdy;
  assign adv   = a_vld && a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (a_rdy) begin
      vld_r <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign b_vld = vld_r;
  assign b_stg = stg_r;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !vld_r)
    else $error("prep stage valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !b_rdy |=> vld_r && $stable(stg_r))
    else $error("prep stage changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/core/sqo_eval.sv =====
// Eval stage: corner cross products, strict edge crossing and the result register.
`default_nettype none
module sqo_eval
  import sqo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic b_vld,
  output logic      b_rdy,
  input  wire stg_t b_stg,
  output logic      o_vld,
  input  wire logic o_rdy,
  output logic      o_hit
);

  logic vld_r;
  logic hit_r;
  logic hit_nxt;

  // cross(q - p, corner - p) at the four corners
  logic signed [K_W-1:0] k00, k10, k11, k01;
  logic [3:0]            cd_opp;

  always_comb begin
    k00 = K_W'(b_stg.dx_dy0) - K_W'(b_stg.dy_dx0);
    k10 = k00 - K_W'(b_stg.dy_s);
    k01 = k00 + K_W'(b_stg.dx_s);
    k11 = k01 - K_W'(b_stg.dy_s);
    cd_opp[0] = opp_sign(k00, k10);
    cd_opp[1] = opp_sign(k10, k11);
    cd_opp[2] = opp_sign(k11, k01);
    cd_opp[3] = opp_sign(k00, k01);
    hit_nxt = b_stg.pt_in || (|(cd_opp & b_stg.edge_opp));
  end

  assign b_rdy = !vld_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (b_rdy) begin
      vld_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld && b_rdy) begin
      hit_r <= hit_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_hit = hit_r;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld && !vld_r |=> vld_r)
    else $error("result register missed a request");

  a_pt_hit: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld && b_rdy && b_stg.pt_in |=> hit_r)
    else $error("endpoint inside square gave no hit");

endmodule
`default_nettype wire

// ===== rtl/core/segment_square_overlap_test_top.sv =====
// Top level: stream ports, side register and input register of the overlap test.
//
// Hit test of a line segment against an axis-aligned closed square.
// in_*  : one request per handshake; in_tdata from bit 0 up holds square_x,
//         square_y, start_x, start_y, end_x, end_y, 16-bit signed each.
// out_* : one result per request, in order; out_tdata[0] is hit, bits 7:1 zero.
// cfg_* : cfg_wr_en writes cfg_wr_data into the square side register at the
//         clock edge; change it only while no request is in flight.
// Pipeline: input register, a stage of four 17x17 multipliers for the
// cross-product terms, then the add/sign stage into the output register.
// A request passes the input register, the prep register and the output register
// in turn before out_tvalid rises. One request per cycle is sustained while
// out_tready is high: each stage reloads in the cycle it hands a request on.
// Reset (rst_n low, synchronous) empties all stages and sets the side to 100.
// When out_tready is low the stages fill up and in_tready drops once the
// pipeline is full; nothing is lost, and in_tready rises again with out_tready.
`default_nettype none
module segment_square_overlap_test_top
  import sqo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // square_x, square_y, start_x, start_y, end_x, end_y
  input  wire logic [IN_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // hit, then zero padding
  output logic [OUT_W-1:0]       out_tdata,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIDE_W-1:0] cfg_wr_data
);

  logic [SIDE_W-1:0] side_r;
  logic              a_vld_r;
  req_t              a_req_r;
  req_t              req_nxt;
  logic              a_rdy;
  logic              b_vld;
  logic              b_rdy;
  stg_t              b_stg;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_wr_en) begin
      side_r <= cfg_wr_data;
    end
  end

  always_comb begin
    req_nxt.sq_x = $signed(in_tdata[0*COORD_W +: COORD_W]);
    req_nxt.sq_y = $signed(in_tdata[1*COORD_W +: COORD_W]);
    req_nxt.px   = $signed(in_tdata[2*COORD_W +: COORD_W]);
    req_nxt.py   = $signed(in_tdata[3*COORD_W +: COORD_W]);
    req_nxt.qx   = $signed(in_tdata[4*COORD_W +: COORD_W]);
    req_nxt.qy   = $signed(in_tdata[5*COORD_W +: COORD_W]);
  end

  assign in_tready = !a_vld_r || a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tready) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_req_r <= req_nxt;
    end
  end

  sqo_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .a_vld (a_vld_r),
    .a_rdy (a_rdy),
    .a_req (a_req_r),
    .side  (side_r),
    .b_vld (b_vld),
    .b_rdy (b_rdy),
    .b_stg (b_stg)
  );

  sqo_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .b_vld (b_vld),
    .b_rdy (b_rdy),
    .b_stg (b_stg),
    .o_vld (out_tvalid),
    .o_rdy (out_tready),
    .o_hit (hit)
  );

  assign out_tdata = {{(OUT_W-1){1'b0}}, hit};

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_vld_r |-> in_tready)
    else $error("input register empty but request refused");

  a_side_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> side_r == $past(cfg_wr_data))
    else $error("side register write lost");

endmodule
`default_nettype wire

// ===== verif/segment_square_overlap_hit_checker.sv =====
// Checker: watches the request and result streams, predicts each hit flag and compares.
module segment_square_overlap_hit_checker
  import sqo_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  // square_x, square_y, start_x, start_y, end_x, end_y
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  // hit, then zero padding
  input  wire logic [OUT_W-1:0]  out_tdata,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIDE_W-1:0] cfg_wr_data,
  output int                     mismatches,
  output int                     pending
);

  logic [SIDE_W-1:0] side_reg = SIDE_RESET;
  bit                expected_hits[$];
  bit                want;
  int                miss_total = 0;

  // sign of ux*vy - uy*vx; operands stay below 2^18, so 64 bits never overflow
  function automatic int cross_dir(input longint ux, uy, vx, vy);
    longint d;
    d = ux * vy - uy * vx;
    return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
  endfunction

  // segments a-b and c-d cross with both sign pairs strictly opposite
  function automatic bit proper_cross(input longint ax, ay, bx, by, cx, cy, dx, dy);
    int s1, s2, s3, s4;
    s1 = cross_dir(bx - ax, by - ay, cx - ax, cy - ay);
    s2 = cross_dir(bx - ax, by - ay, dx - ax, dy - ay);
    s3 = cross_dir(dx - cx, dy - cy, ax - cx, ay - cy);
    s4 = cross_dir(dx - cx, dy - cy, bx - cx, by - cy);
    return (s1 * s2 < 0) && (s3 * s4 < 0);
  endfunction

  function automatic bit predict_hit(input logic [IN_W-1:0] req, input longint side);
    longint x0, y0, px, py, qx, qy, x1, y1;
    x0 = longint'($signed(req[0*COORD_W +: COORD_W]));
    y0 = longint'($signed(req[1*COORD_W +: COORD_W]));
    px = longint'($signed(req[2*COORD_W +: COORD_W]));
    py = longint'($signed(req[3*COORD_W +: COORD_W]));
    qx = longint'($signed(req[4*COORD_W +: COORD_W]));
    qy = longint'($signed(req[5*COORD_W +: COORD_W]));
    x1 = x0 + side;
    y1 = y0 + side;
    if (px >= x0 && px <= x1 && py >= y0 && py <= y1)
      return 1'b1;
    if (qx >= x0 && qx <= x1 && qy >= y0 && qy <= y1)
      return 1'b1;
    return proper_cross(x0, y0, x1, y0, px, py, qx, qy) ||
           proper_cross(x1, y0, x1, y1, px, py, qx, qy) ||
           proper_cross(x1, y1, x0, y1, px, py, qx, qy) ||
           proper_cross(x0, y0, x0, y1, px, py, qx, qy);
  endfunction

  task automatic report(input string what, input bit want_v, input logic [OUT_W-1:0] got);
    miss_total++;
    if (miss_total <= 10)
      $display("%0t: hit %s: expected %0b, got out_tdata %b", $time, what, want_v, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg = SIDE_RESET;
      expected_hits.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          report("result with nothing expected", 1'b0, out_tdata);
        end else begin
          want = expected_hits.pop_front();
          // padding bits are part of the result and must stay zero
          if (out_tdata[0] !== want || out_tdata[OUT_W-1:1] !== '0)
            report("mismatch", want, out_tdata);
        end
      end
      if (in_tvalid && in_tready)
        expected_hits.push_back(predict_hit(in_tdata, longint'(side_reg)));
      if (cfg_wr_en)
        side_reg = cfg_wr_data;
    end
    pending    <= expected_hits.size();
    mismatches <= miss_total;
  end

endmodule

// ===== verif/segment_square_overlap_test_top_test.sv =====
// Testbench top: clock, reset, request stimulus, result stalls, side writes and verdict.
module segment_square_overlap_test_top_test;
  import sqo_pkg::*;

  typedef enum int {
    SHAPE_RANDOM, SHAPE_AROUND, SHAPE_CROSS, SHAPE_TOUCH,
    SHAPE_POINT, SHAPE_EXTREME, SHAPE_BORDER
  } shape_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_WAVE} ready_mode_t;

  localparam int PHASE_ITEMS  = 185;
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_LIMIT   = 2000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic [IN_W-1:0]   in_tdata    = '0;
  logic              out_tready  = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [SIDE_W-1:0] cfg_wr_data = '0;
  wire logic             in_tready;
  wire logic             out_tvalid;
  wire logic [OUT_W-1:0] out_tdata;
  int                mismatches;
  int                pending;

  ready_mode_t ready_mode  = RDY_ALWAYS;
  int          mode_left   = 0;
  int          wave_len    = 1;
  int          wave_cnt    = 0;
  int          idle_cycles = 0;

  segment_square_overlap_test_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  segment_square_overlap_hit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure: modes switch whenever mode_left runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(3));
      mode_left  <= $urandom_range(40, 240);
      wave_len   <= $urandom_range(1, 12);
    end else begin
      mode_left <= mode_left - 1;
    end
    wave_cnt <= wave_cnt + 1;
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_COIN:   out_tready <= 1'($urandom_range(1));
      RDY_SPARSE: out_tready <= ($urandom_range(3) == 0);
      default:    out_tready <= (wave_cnt % (2 * wave_len)) < wave_len;
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("segment_square_overlap_test_top regression: fail");
      $finish;
    end
  end

  task automatic push_request(input logic [IN_W-1:0] d);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_coords(input int sx, sy, px, py, qx, qy);
    push_request({16'(qy), 16'(qx), 16'(py), 16'(px), 16'(sy), 16'(sx)});
  endtask

  // pending is a registered copy of the queue size, so wait for an edge before looking at it
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(input logic [SIDE_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] offset_coord(input int base, lo, hi);
    return 16'(base + lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic [COORD_W-1:0] extreme_coord();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // on or just beside the square's border lines
  function automatic logic [COORD_W-1:0] border_coord(input int lo, hi);
    case ($urandom_range(4))
      0:       return 16'(lo - 1);
      1:       return 16'(lo);
      2:       return 16'(hi);
      3:       return 16'(hi + 1);
      default: return offset_coord(lo, 0, hi - lo);
    endcase
  endfunction

  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 15) return SHAPE_RANDOM;
    if (r < 35) return SHAPE_AROUND;
    if (r < 60) return SHAPE_CROSS;
    if (r < 75) return SHAPE_TOUCH;
    if (r < 80) return SHAPE_POINT;
    if (r < 90) return SHAPE_EXTREME;
    return SHAPE_BORDER;
  endfunction

  function automatic logic [IN_W-1:0] make_request(input shape_t shape, input int side);
    int x0, y0, x1, y1, m, d, e, ly;
    logic [COORD_W-1:0] f_sx, f_sy, f_px, f_py, f_qx, f_qy;
    x0 = int'($urandom_range(65535)) - 32768;
    y0 = int'($urandom_range(65535)) - 32768;
    x1 = x0 + side;
    y1 = y0 + side;
    m  = side / 2 + 8;
    d  = $urandom_range(1, m);
    e  = $urandom_range(1, m);
    f_sx = 16'(x0);
    f_sy = 16'(y0);
    f_px = 16'($urandom);
    f_py = 16'($urandom);
    f_qx = 16'($urandom);
    f_qy = 16'($urandom);
    case (shape)
      SHAPE_RANDOM: begin
        f_sx = 16'($urandom);
        f_sy = 16'($urandom);
      end
      SHAPE_AROUND: begin
        f_px = offset_coord(x0, -m, side + m);
        f_py = offset_coord(y0, -m, side + m);
        f_qx = offset_coord(x0, -m, side + m);
        f_qy = offset_coord(y0, -m, side + m);
      end
      SHAPE_CROSS: begin
        f_px = offset_coord(x0, -side - m, -1);
        f_qx = offset_coord(x1, 1, side + m);
        f_py = offset_coord(y0, -m, side + m);
        f_qy = offset_coord(y0, -m, side + m);
      end
      SHAPE_TOUCH: begin
        case ($urandom_range(5))
          0: begin
            // lies on the bottom or top edge line, reaching to or past both ends
            ly   = $urandom_range(1) ? y0 : y1;
            f_py = 16'(ly);
            f_qy = 16'(ly);
            f_px = offset_coord(x0, -side - m, 0);
            f_qx = offset_coord(x1, 0, side + m);
          end
          1: begin
            f_px = 16'(x0 - d); f_py = 16'(y0 + d);
            f_qx = 16'(x0 + e); f_qy = 16'(y0 - e);
          end
          2: begin
            f_px = 16'(x1 - d); f_py = 16'(y0 - d);
            f_qx = 16'(x1 + e); f_qy = 16'(y0 + e);
          end
          3: begin
            f_px = 16'(x1 + d); f_py = 16'(y1 - d);
            f_qx = 16'(x1 - e); f_qy = 16'(y1 + e);
          end
          4: begin
            f_px = 16'(x0 - d); f_py = 16'(y1 - d);
            f_qx = 16'(x0 + e); f_qy = 16'(y1 + e);
          end
          default: begin
            // diagonal through two opposite corners and across the inside
            f_px = 16'(x0 - d); f_py = 16'(y0 - d);
            f_qx = 16'(x1 + e); f_qy = 16'(y1 + e);
          end
        endcase
      end
      SHAPE_POINT: begin
        f_px = offset_coord(x0, -m, side + m);
        f_py = offset_coord(y0, -m, side + m);
        f_qx = f_px;
        f_qy = f_py;
      end
      SHAPE_EXTREME: begin
        f_sx = extreme_coord();
        f_sy = extreme_coord();
        f_px = extreme_coord();
        f_py = extreme_coord();
        f_qx = extreme_coord();
        f_qy = extreme_coord();
      end
      default: begin
        f_px = border_coord(x0, x1);
        f_py = border_coord(y0, y1);
        f_qx = border_coord(x0, x1);
        f_qy = border_coord(y0, y1);
      end
    endcase
    if ($urandom_range(1))
      {f_px, f_py, f_qx, f_qy} = {f_qx, f_qy, f_px, f_py};
    if ($urandom_range(1))
      {f_sx, f_sy, f_px, f_py, f_qx, f_qy} = {f_sy, f_sx, f_py, f_px, f_qy, f_qx};
    return {f_qy, f_qx, f_py, f_px, f_sy, f_sx};
  endfunction

  task automatic run_random(input int n, input int side);
    int burst, gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, ($urandom_range(3) == 0) ? 64 : 16);
        gap   = ($urandom_range(2) == 0) ? 0 :
                $urandom_range(1, ($urandom_range(5) == 0) ? 20 : 4);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      push_request(make_request(pick_shape(), side));
      burst--;
    end
  endtask

  initial begin
    int sides[$];
    sides = {1, 32767, int'($urandom_range(3, 32766)), 2,
             int'($urandom_range(3, 300)), 16384};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset side of 100, square at the origin unless noted
    send_coords(0, 0, 50, 50, 1000, 1000);      // start inside
    send_coords(0, 0, 0, 0, -500, -7);          // start on the corner
    send_coords(0, 0, 100, 100, 900, -900);     // start on the far corner
    send_coords(0, 0, 101, 50, 300, 50);        // one unit outside, heading away
    send_coords(0, 0, -50, 50, 150, 50);        // straight through
    send_coords(0, 0, 50, -200, 50, 300);       // vertical through
    send_coords(0, 0, -30, 80, 80, 130);        // clips the upper-left area
    send_coords(0, 0, -50, 0, 150, 0);          // collinear with the bottom edge
    send_coords(0, 0, -50, 50, 50, -50);        // touches a corner only
    send_coords(0, 0, -50, -50, 150, 150);      // through two corners
    send_coords(0, 0, 150, 0, 150, -50);        // beside, no contact
    send_coords(0, 0, 50, 50, 50, 50);          // zero-length inside
    send_coords(0, 0, 200, 200, 200, 200);      // zero-length outside
    send_coords(32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768);
    send_coords(32767, -32768, -32768, 32767, 32767, -32768);
    send_coords(-32768, 32767, -32768, -32768, 32767, 32767);
    send_coords(-1, -1, -1, -1, 0, 0);
    send_coords(-100, -100, -200, -50, 10, -50);
    send_coords(0, 0, -1, -1, -1, 101);         // just left of the left edge
    run_random(PHASE_ITEMS, int'(SIDE_RESET));

    foreach (sides[k]) begin
      drain();
      write_side(SIDE_W'(sides[k]));
      run_random(PHASE_ITEMS, sides[k]);
    end

    drain();
    if (mismatches == 0)
      $display("segment_square_overlap_test_top regression: pass");
    else
      $display("segment_square_overlap_test_top regression: fail");
    $finish;
  end

endmodule
